// ===== hw/rtl/psrc_pkg.sv =====
// Package for the pedal speed ramp controller: widths, reset values,
// register map and the constant functions that build the duty and blink tables.
// Depends on nothing; every other file of the block uses it.
package psrc_pkg;

  localparam int unsigned DUTY_BITS_DEF = 13;
  localparam int unsigned SPEED_W       = 15;
  localparam int unsigned LEVEL_W       = 7;
  localparam int unsigned MS_W          = 10;
  localparam int unsigned BAND_W        = 14;
  localparam int unsigned BLINK_W       = 10;
  localparam int unsigned ADDR_W        = 5;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned PCT_ENTRIES   = 1 << LEVEL_W;

  // Division by one hundred of values below 2^14: (x * 5243) >> 19.
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [LEVEL_W-1:0] PCT_FULL      = 7'd100;
  localparam logic [BAND_W-1:0]  BRAKE_FAST_AT = 14'd5000;
  localparam logic [BLINK_W-1:0] BLINK_STOP    = 10'd200;
  localparam logic [BLINK_W-1:0] BLINK_IDLE    = 10'd1000;

  // Register map, word index in paddr[4:2].
  typedef enum logic [2:0] {
    REG_SPEED_DIR_MODE = 3'd0,
    REG_MAX_FORWARD    = 3'd1,
    REG_MAX_BACKWARD   = 3'd2,
    REG_DRAG_MODE      = 3'd3,
    REG_FWD_SHUTOFF    = 3'd4,
    REG_BWD_SHUTOFF    = 3'd5,
    REG_NORMAL_INC     = 3'd6,
    REG_DRAG_INC       = 3'd7
  } reg_idx_t;

  localparam logic [LEVEL_W-1:0] RST_MAX_PERCENT = 7'd50;
  localparam logic [BAND_W-1:0]  RST_SHUTOFF     = 14'd1000;
  localparam logic [BAND_W-1:0]  RST_NORMAL_INC  = 14'd100;
  localparam logic [BAND_W-1:0]  RST_DRAG_INC    = 14'd200;

  // Rounded duty for a whole percent, ties away from zero.
  function automatic longint unsigned duty_of(int unsigned pct, int unsigned bits);
    longint unsigned full;
    full = (longint'(1) << bits) - 1;
    return (longint'(pct) * full + 50) / 100;
  endfunction

  // LED half period for a nonzero whole-percent magnitude.
  function automatic int unsigned blink_of(int unsigned pct);
    int unsigned mag;
    mag = (pct > 100) ? 100 : pct;
    return 20 + ((100 - mag) * 160) / 100;
  endfunction

endpackage

// ===== hw/rtl/psrc_chan_if.sv =====
// Request and result channel interfaces of the pedal speed ramp controller.
// Depends on psrc_pkg for field widths.
interface psrc_in_if;
  logic                          valid;
  logic                          ready;
  logic [psrc_pkg::LEVEL_W-1:0]  forward_level;
  logic [psrc_pkg::LEVEL_W-1:0]  backward_level;
  logic [psrc_pkg::LEVEL_W-1:0]  throttle_level;
  logic [psrc_pkg::MS_W-1:0]     elapsed_ms;
  logic                          emergency_stop;

  modport source (output valid, forward_level, backward_level, throttle_level,
                  elapsed_ms, emergency_stop, input ready);
  modport sink   (input valid, forward_level, backward_level, throttle_level,
                  elapsed_ms, emergency_stop, output ready);
endinterface

interface psrc_out_if #(
  parameter int unsigned DUTY_BITS = psrc_pkg::DUTY_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic signed [psrc_pkg::SPEED_W-1:0] speed_hundredths;
  logic [DUTY_BITS-1:0]                fwd_pwm;
  logic [DUTY_BITS-1:0]                bwd_pwm;
  logic [psrc_pkg::BLINK_W-1:0]        blink_half_period_ms;

  modport source (output valid, speed_hundredths, fwd_pwm, bwd_pwm,
                  blink_half_period_ms, input ready);
  modport sink   (input valid, speed_hundredths, fwd_pwm, bwd_pwm,
                  blink_half_period_ms, output ready);
endinterface

// ===== hw/rtl/pedal_speed_ramp_controller_core.sv =====
// Top level of the pedal speed ramp controller: register file, target
// stages, speed ramp and result register. Depends on psrc_pkg and psrc_chan_if.
//
//   channel   direction  handshake                 content
//   in_chan   sink       valid/ready               one control tick request
//   out_chan  source     valid/ready               speed, two duties, blink
//   psel...   slave      APB r/w, pready high      eight config registers
//
// A request passes four registers (input, target, speed, result) in order,
// and one request can be taken every cycle while out_chan is not stalled.
// The only loop is the kept speed, which the speed register updates from the
// target and the old speed, so back-to-back requests see each other.
// All stages move together when the result register is empty or being taken,
// so a stall on out_chan holds every stage and deasserts in_chan.ready.
// Reset (synchronous, rst_n low) clears the valid bits, the kept speed and
// the configuration registers to their documented defaults.
module pedal_speed_ramp_controller_core #(
  parameter int unsigned DUTY_BITS = psrc_pkg::DUTY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  psrc_in_if.sink                        in_chan,
  psrc_out_if.source                     out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [psrc_pkg::ADDR_W-1:0]    paddr,
  input  logic [psrc_pkg::DATA_W-1:0]    pwdata,
  output logic [psrc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int unsigned LW = psrc_pkg::LEVEL_W;
  localparam int unsigned BW = psrc_pkg::BAND_W;
  localparam int unsigned MW = psrc_pkg::MS_W;
  localparam int unsigned SW = psrc_pkg::SPEED_W;
  localparam int unsigned RW = 18;                       // ramp working width
  localparam int unsigned PW = BW + psrc_pkg::RECIP_W;   // reciprocal product

  // ------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase.
  // ------------------------------------------------------------------
  logic          mode_r;
  logic [LW-1:0] max_fwd_r;
  logic [LW-1:0] max_bwd_r;
  logic          drag_r;
  logic [BW-1:0] fwd_shut_r;
  logic [BW-1:0] bwd_shut_r;
  logic [BW-1:0] norm_inc_r;
  logic [BW-1:0] drag_inc_r;

  psrc_pkg::reg_idx_t reg_idx;
  logic               cfg_wr;

  assign reg_idx = psrc_pkg::reg_idx_t'(paddr[4:2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      max_fwd_r  <= psrc_pkg::RST_MAX_PERCENT;
      max_bwd_r  <= psrc_pkg::RST_MAX_PERCENT;
      drag_r     <= 1'b0;
      fwd_shut_r <= psrc_pkg::RST_SHUTOFF;
      bwd_shut_r <= psrc_pkg::RST_SHUTOFF;
      norm_inc_r <= psrc_pkg::RST_NORMAL_INC;
      drag_inc_r <= psrc_pkg::RST_DRAG_INC;
    end else if (cfg_wr) begin
      case (reg_idx)
        psrc_pkg::REG_SPEED_DIR_MODE: mode_r     <= pwdata[0];
        psrc_pkg::REG_MAX_FORWARD:    max_fwd_r  <= pwdata[LW-1:0];
        psrc_pkg::REG_MAX_BACKWARD:   max_bwd_r  <= pwdata[LW-1:0];
        psrc_pkg::REG_DRAG_MODE:      drag_r     <= pwdata[0];
        psrc_pkg::REG_FWD_SHUTOFF:    fwd_shut_r <= pwdata[BW-1:0];
        psrc_pkg::REG_BWD_SHUTOFF:    bwd_shut_r <= pwdata[BW-1:0];
        psrc_pkg::REG_NORMAL_INC:     norm_inc_r <= pwdata[BW-1:0];
        psrc_pkg::REG_DRAG_INC:       drag_inc_r <= pwdata[BW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      psrc_pkg::REG_SPEED_DIR_MODE: prdata = {31'd0, mode_r};
      psrc_pkg::REG_MAX_FORWARD:    prdata = {25'd0, max_fwd_r};
      psrc_pkg::REG_MAX_BACKWARD:   prdata = {25'd0, max_bwd_r};
      psrc_pkg::REG_DRAG_MODE:      prdata = {31'd0, drag_r};
      psrc_pkg::REG_FWD_SHUTOFF:    prdata = {18'd0, fwd_shut_r};
      psrc_pkg::REG_BWD_SHUTOFF:    prdata = {18'd0, bwd_shut_r};
      psrc_pkg::REG_NORMAL_INC:     prdata = {18'd0, norm_inc_r};
      psrc_pkg::REG_DRAG_INC:       prdata = {18'd0, drag_inc_r};
      default:                      prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Pipeline control: every stage advances when the result register is
  // free or its result is being taken.
  // ------------------------------------------------------------------
  logic out_valid_r;
  logic advance;

  assign advance       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = advance;

  // ------------------------------------------------------------------
  // Stage A: the accepted request.
  // ------------------------------------------------------------------
  logic          a_valid_r;
  logic [LW-1:0] a_fwd_r;
  logic [LW-1:0] a_bwd_r;
  logic [LW-1:0] a_thr_r;
  logic [MW-1:0] a_ms_r;
  logic          a_stop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_fwd_r  <= in_chan.forward_level;
      a_bwd_r  <= in_chan.backward_level;
      a_thr_r  <= in_chan.throttle_level;
      a_ms_r   <= in_chan.elapsed_ms;
      a_stop_r <= in_chan.emergency_stop;
    end
  end

  // ------------------------------------------------------------------
  // A to B: pick direction, limit and level, and form limit * level.
  // The target is zero unless exactly one direction is active, and in
  // speed/direction mode also when the throttle is released.
  // ------------------------------------------------------------------
  logic            fwd_on;
  logic            bwd_on;
  logic            tgt_zero;
  logic [LW-1:0]   lim_raw;
  logic [LW-1:0]   lim;
  logic [LW-1:0]   level;
  logic [BW-1:0]   share_prod;

  assign fwd_on   = (a_fwd_r != '0);
  assign bwd_on   = (a_bwd_r != '0);
  assign tgt_zero = (fwd_on == bwd_on) || (mode_r && (a_thr_r == '0));
  assign lim_raw  = fwd_on ? max_fwd_r : max_bwd_r;
  assign lim      = (lim_raw > psrc_pkg::PCT_FULL) ? psrc_pkg::PCT_FULL : lim_raw;
  assign level    = mode_r ? a_thr_r : (fwd_on ? a_fwd_r : a_bwd_r);
  assign share_prod = BW'(lim * level);

  logic          b_valid_r;
  logic          b_zero_r;
  logic          b_neg_r;
  logic [LW-1:0] b_lim_r;
  logic [BW-1:0] b_prod_r;
  logic [MW-1:0] b_ms_r;
  logic          b_stop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (advance) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_zero_r <= tgt_zero;
      b_neg_r  <= !fwd_on;
      b_lim_r  <= lim;
      b_prod_r <= share_prod;
      b_ms_r   <= a_ms_r;
      b_stop_r <= a_stop_r;
    end
  end

  // ------------------------------------------------------------------
  // B to C: target in hundredths, then one ramp step of the kept speed.
  // ------------------------------------------------------------------
  logic [PW-1:0]        share_recip;
  logic [LW-1:0]        share_pct;
  logic [LW-1:0]        tgt_pct;
  logic [BW-1:0]        tgt_mag;
  logic signed [RW-1:0] tgt;

  assign share_recip = PW'(b_prod_r * psrc_pkg::RECIP_W'(psrc_pkg::RECIP_100));
  assign share_pct   = share_recip[psrc_pkg::RECIP_SHIFT +: LW];
  assign tgt_pct     = (share_pct < b_lim_r) ? share_pct : b_lim_r;
  assign tgt_mag     = BW'(tgt_pct * psrc_pkg::PCT_FULL);

  always_comb begin
    if (b_zero_r) begin
      tgt = '0;
    end else if (b_neg_r) begin
      tgt = -$signed({{(RW-BW){1'b0}}, tgt_mag});
    end else begin
      tgt = $signed({{(RW-BW){1'b0}}, tgt_mag});
    end
  end

  logic signed [SW-1:0] speed_r;
  logic signed [SW-1:0] speed_nxt;
  logic signed [RW-1:0] spd;
  logic [SW-1:0]        spd_mag;
  logic signed [RW-1:0] fwd_shut;
  logic signed [RW-1:0] bwd_shut;
  logic signed [RW-1:0] brake;
  logic signed [RW-1:0] accel;
  logic signed [RW-1:0] decel;
  logic signed [RW-1:0] ramp;
  logic                 in_fwd_band;
  logic                 in_bwd_band;

  assign spd      = RW'(speed_r);
  assign spd_mag  = speed_r[SW-1] ? SW'(-speed_r) : SW'(speed_r);
  assign fwd_shut = $signed({{(RW-BW){1'b0}}, fwd_shut_r});
  assign bwd_shut = $signed({{(RW-BW){1'b0}}, bwd_shut_r});
  // Braking is 8 hundredths per ms above half speed, 4 below.
  assign brake    = (spd_mag > SW'(psrc_pkg::BRAKE_FAST_AT))
                  ? $signed({{(RW-MW-3){1'b0}}, b_ms_r, 3'b000})
                  : $signed({{(RW-MW-2){1'b0}}, b_ms_r, 2'b00});
  assign accel    = $signed({{(RW-BW){1'b0}}, (drag_r ? drag_inc_r : norm_inc_r)});
  assign decel    = $signed({{(RW-BW){1'b0}}, norm_inc_r});
  assign in_fwd_band = (spd > 0) && (spd < fwd_shut);
  assign in_bwd_band = (spd < 0) && (spd > -bwd_shut);

  // The step never carries the speed past the target.
  always_comb begin
    if (spd < tgt) begin
      if (in_bwd_band) begin
        ramp = '0;
      end else if (in_fwd_band) begin
        ramp = fwd_shut;
      end else if (spd < 0) begin
        ramp = spd + brake;
      end else begin
        ramp = spd + accel;
      end
      if (ramp > tgt) begin
        ramp = tgt;
      end
    end else if (spd > tgt) begin
      if (in_fwd_band) begin
        ramp = '0;
      end else if (in_bwd_band) begin
        ramp = -bwd_shut;
      end else if (spd > 0) begin
        ramp = spd - brake;
      end else begin
        ramp = spd - decel;
      end
      if (ramp < tgt) begin
        ramp = tgt;
      end
    end else begin
      ramp = spd;
    end
  end

  assign speed_nxt = b_stop_r ? '0 : SW'(ramp);

  logic c_valid_r;
  logic c_stop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      speed_r   <= '0;
    end else if (advance) begin
      c_valid_r <= b_valid_r;
      if (b_valid_r) begin
        speed_r <= speed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_stop_r <= b_stop_r;
    end
  end

  // ------------------------------------------------------------------
  // C to result: whole percent, duties and blink from constant tables.
  // The kept speed is the speed of the item in stage C.
  // ------------------------------------------------------------------
  logic [DUTY_BITS-1:0]         duty_tbl  [psrc_pkg::PCT_ENTRIES];
  logic [psrc_pkg::BLINK_W-1:0] blink_tbl [psrc_pkg::PCT_ENTRIES];

  for (genvar g = 0; g < psrc_pkg::PCT_ENTRIES; g++) begin : g_tbl
    localparam logic [DUTY_BITS-1:0] DUTY_V =
      DUTY_BITS'(psrc_pkg::duty_of(g, DUTY_BITS));
    localparam logic [psrc_pkg::BLINK_W-1:0] BLINK_V =
      psrc_pkg::BLINK_W'(psrc_pkg::blink_of(g));
    assign duty_tbl[g]  = DUTY_V;
    assign blink_tbl[g] = BLINK_V;
  end

  logic [PW-1:0]                pct_recip;
  logic [LW-1:0]                pct_mag;
  logic                         pct_fwd;
  logic                         pct_bwd;
  logic [DUTY_BITS-1:0]         fwd_duty_nxt;
  logic [DUTY_BITS-1:0]         bwd_duty_nxt;
  logic [psrc_pkg::BLINK_W-1:0] blink_nxt;

  assign pct_recip = PW'(spd_mag[BW-1:0] * psrc_pkg::RECIP_W'(psrc_pkg::RECIP_100));
  assign pct_mag   = pct_recip[psrc_pkg::RECIP_SHIFT +: LW];
  assign pct_fwd   = !speed_r[SW-1] && (pct_mag != '0);
  assign pct_bwd   = speed_r[SW-1] && (pct_mag != '0);

  assign fwd_duty_nxt = pct_fwd ? duty_tbl[pct_mag] : '0;
  assign bwd_duty_nxt = pct_bwd ? duty_tbl[pct_mag] : '0;

  always_comb begin
    if (c_stop_r) begin
      blink_nxt = psrc_pkg::BLINK_STOP;
    end else if (pct_mag == '0) begin
      blink_nxt = psrc_pkg::BLINK_IDLE;
    end else begin
      blink_nxt = blink_tbl[pct_mag];
    end
  end

  logic signed [SW-1:0]         out_speed_r;
  logic [DUTY_BITS-1:0]         out_fduty_r;
  logic [DUTY_BITS-1:0]         out_bduty_r;
  logic [psrc_pkg::BLINK_W-1:0] out_blink_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_speed_r <= speed_r;
      out_fduty_r <= fwd_duty_nxt;
      out_bduty_r <= bwd_duty_nxt;
      out_blink_r <= blink_nxt;
    end
  end

  assign out_chan.valid                = out_valid_r;
  assign out_chan.speed_hundredths     = out_speed_r;
  assign out_chan.fwd_pwm              = out_fduty_r;
  assign out_chan.bwd_pwm              = out_bduty_r;
  assign out_chan.blink_half_period_ms = out_blink_r;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pedal_speed_ramp_controller_core: drives control-tick
// requests and APB register writes, and checks every result against a built-in predictor.
// Depends on psrc_pkg and the psrc_in_if / psrc_out_if channel interfaces.
module tb_top;
  import psrc_pkg::*;

  localparam int DUTY_W      = DUTY_BITS_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 8;

  // One control tick as it is offered on the request channel.
  typedef struct packed {
    logic [LEVEL_W-1:0] forward_level;
    logic [LEVEL_W-1:0] backward_level;
    logic [LEVEL_W-1:0] throttle_level;
    logic [MS_W-1:0]    elapsed_ms;
    logic               emergency_stop;
  } tick_t;

  // What the block should report for one tick.
  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic [DUTY_W-1:0]         fwd_duty;
    logic [DUTY_W-1:0]         bwd_duty;
    logic [BLINK_W-1:0]        blink;
  } speed_report_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  psrc_in_if                        req_if ();
  psrc_out_if #(.DUTY_BITS(DUTY_W)) res_if ();

  pedal_speed_ramp_controller_core #(.DUTY_BITS(DUTY_W)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Predictor state: our own copy of the configuration and of the kept speed.
  logic               cfg_speed_dir;
  logic [LEVEL_W-1:0] cfg_max_fwd;
  logic [LEVEL_W-1:0] cfg_max_bwd;
  logic               cfg_drag;
  logic [BAND_W-1:0]  cfg_fwd_shutoff;
  logic [BAND_W-1:0]  cfg_bwd_shutoff;
  logic [BAND_W-1:0]  cfg_normal_inc;
  logic [BAND_W-1:0]  cfg_drag_inc;
  int                 kept_speed;

  // Results owed by the block, oldest first.
  speed_report_t speed_reports_due[$];

  int mismatches;
  int cycle_count;

  // Idling knobs, in percent of cycles.
  int src_idle_pct;
  int sink_stall_pct;

  // A long hold-off of the result channel is requested by bumping the sequence number;
  // the ready process then counts the cycles down on its own.
  int hold_cycles_req;
  int hold_req_seq;
  int hold_seen_seq;
  int hold_left;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Share of a percentage limit taken by a level; limits above one hundred count as one
  // hundred, and levels above one hundred saturate at the limit.
  function automatic int percent_share(input int limit, input int level);
    int lim;
    int v;
    lim = (limit > 100) ? 100 : limit;
    v   = (lim * level) / 100;
    return (v < lim) ? v : lim;
  endfunction

  // PWM duty for a whole percent, rounded half away from zero.
  function automatic logic [DUTY_W-1:0] duty_for(input int pct);
    longint full;
    full = (longint'(1) << DUTY_W) - 1;
    return DUTY_W'((longint'(pct) * full + 50) / 100);
  endfunction

  // Advances the kept speed by one tick and returns what the block must report for it.
  function automatic speed_report_t ramp_tick(input tick_t t);
    speed_report_t r;
    bit fwd_on;
    bit bwd_on;
    int level;
    int tgt;
    int s;
    int n;
    int fs;
    int bs;
    int mag;
    int brake;
    int pct;
    r = '0;
    if (t.emergency_stop) begin
      kept_speed = 0;
      r.blink    = BLINK_STOP;
    end else begin
      // Target in hundredths: exactly one direction must be active, and in
      // speed/direction mode a closed throttle means no target at all.
      fwd_on = (t.forward_level != 0);
      bwd_on = (t.backward_level != 0);
      tgt    = 0;
      if (fwd_on != bwd_on && !(cfg_speed_dir && t.throttle_level == 0)) begin
        if (cfg_speed_dir) begin
          level = int'(t.throttle_level);
        end else begin
          level = fwd_on ? int'(t.forward_level) : int'(t.backward_level);
        end
        tgt = fwd_on ? 100 * percent_share(int'(cfg_max_fwd), level)
                     : -100 * percent_share(int'(cfg_max_bwd), level);
      end
      // One ramp step: snap inside the shutoff bands, brake in proportion to the elapsed
      // time, or accelerate by the increment; never pass the target.
      s     = kept_speed;
      fs    = int'(cfg_fwd_shutoff);
      bs    = int'(cfg_bwd_shutoff);
      mag   = (s < 0) ? -s : s;
      brake = int'(t.elapsed_ms) * ((mag > 5000) ? 8 : 4);
      if (s < tgt) begin
        if (s < 0 && s > -bs) begin
          n = 0;
        end else if (s > 0 && s < fs) begin
          n = fs;
        end else if (s < 0) begin
          n = s + brake;
        end else begin
          n = s + (cfg_drag ? int'(cfg_drag_inc) : int'(cfg_normal_inc));
        end
        if (n > tgt) n = tgt;
      end else if (s > tgt) begin
        if (s > 0 && s < fs) begin
          n = 0;
        end else if (s < 0 && s > -bs) begin
          n = -bs;
        end else if (s > 0) begin
          n = s - brake;
        end else begin
          n = s - int'(cfg_normal_inc);
        end
        if (n < tgt) n = tgt;
      end else begin
        n = s;
      end
      kept_speed = n;
      pct        = n / 100;
      if (pct > 0) begin
        r.fwd_duty = duty_for(pct);
      end else if (pct < 0) begin
        r.bwd_duty = duty_for(-pct);
      end
      if (pct == 0) begin
        r.blink = BLINK_IDLE;
      end else begin
        mag     = (pct < 0) ? -pct : pct;
        mag     = (mag > 100) ? 100 : mag;
        r.blink = BLINK_W'(20 + ((100 - mag) * 160) / 100);
      end
    end
    r.speed = kept_speed[SPEED_W-1:0];
    return r;
  endfunction

  // Result channel ready: a requested hold-off takes precedence, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_req_seq != hold_seen_seq) begin
      hold_seen_seq = hold_req_seq;
      hold_left     = hold_cycles_req;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Every accepted result is matched against the oldest outstanding expectation.
  always @(posedge clk) begin : check_results
    speed_report_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (speed_reports_due.size() == 0) begin
        report_mismatch("result with no request outstanding, speed",
                        res_if.speed_hundredths, 0);
      end else begin
        want = speed_reports_due.pop_front();
        if (res_if.speed_hundredths !== want.speed)
          report_mismatch("speed_hundredths", res_if.speed_hundredths, want.speed);
        if (res_if.fwd_pwm !== want.fwd_duty)
          report_mismatch("fwd_pwm", res_if.fwd_pwm, want.fwd_duty);
        if (res_if.bwd_pwm !== want.bwd_duty)
          report_mismatch("bwd_pwm", res_if.bwd_pwm, want.bwd_duty);
        if (res_if.blink_half_period_ms !== want.blink)
          report_mismatch("blink_half_period_ms", res_if.blink_half_period_ms, want.blink);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one request, with random idle cycles in front of it, and books its expected
  // result at the edge where it is accepted. Called and returns at a falling edge; valid is
  // left high so that back-to-back requests need no extra assignment.
  task automatic send_request(input tick_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid          <= 1'b1;
    req_if.forward_level  <= t.forward_level;
    req_if.backward_level <= t.backward_level;
    req_if.throttle_level <= t.throttle_level;
    req_if.elapsed_ms     <= t.elapsed_ms;
    req_if.emergency_stop <= t.emergency_stop;
    do @(posedge clk); while (!req_if.ready);
    speed_reports_due.push_back(ramp_tick(t));
    @(negedge clk);
  endtask

  task automatic send_tick(input int fwd, input int bwd, input int thr, input int ms,
                           input bit stop);
    tick_t t;
    t.forward_level  = LEVEL_W'(fwd);
    t.backward_level = LEVEL_W'(bwd);
    t.throttle_level = LEVEL_W'(thr);
    t.elapsed_ms     = MS_W'(ms);
    t.emergency_stop = stop;
    send_request(t);
  endtask

  // Stops offering requests and waits until every outstanding result has been taken,
  // so the block is idle afterwards.
  task automatic wait_until_idle;
    req_if.valid <= 1'b0;
    do @(negedge clk); while (speed_reports_due.size() != 0);
  endtask

  // APB write followed by a read-back. Junk above the register's width checks that
  // the block keeps only the low bits. Must be called while the block is idle.
  task automatic write_register(input reg_idx_t idx, input int unsigned value);
    int unsigned       w;
    logic [DATA_W-1:0] kept;
    logic [DATA_W-1:0] word;
    case (idx)
      REG_SPEED_DIR_MODE, REG_DRAG_MODE: w = 1;
      REG_MAX_FORWARD, REG_MAX_BACKWARD: w = LEVEL_W;
      default:                           w = BAND_W;
    endcase
    kept = value & ((32'd1 << w) - 1);
    word = ($urandom << w) | kept;
    case (idx)
      REG_SPEED_DIR_MODE: cfg_speed_dir   = kept[0];
      REG_MAX_FORWARD:    cfg_max_fwd     = kept[LEVEL_W-1:0];
      REG_MAX_BACKWARD:   cfg_max_bwd     = kept[LEVEL_W-1:0];
      REG_DRAG_MODE:      cfg_drag        = kept[0];
      REG_FWD_SHUTOFF:    cfg_fwd_shutoff = kept[BAND_W-1:0];
      REG_BWD_SHUTOFF:    cfg_bwd_shutoff = kept[BAND_W-1:0];
      REG_NORMAL_INC:     cfg_normal_inc  = kept[BAND_W-1:0];
      REG_DRAG_INC:       cfg_drag_inc    = kept[BAND_W-1:0];
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== kept) report_mismatch($sformatf("read-back of register %s", idx.name()),
                                         prdata, kept);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Writes all eight registers. With extremes set each one goes to the bottom or the top
  // of its field; otherwise values are mostly plausible, with the odd wild one.
  task automatic apply_random_settings(input bit extremes);
    int          i;
    int unsigned top;
    int unsigned value;
    reg_idx_t    idx;
    for (i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      case (idx)
        REG_SPEED_DIR_MODE, REG_DRAG_MODE: top = 1;
        REG_MAX_FORWARD, REG_MAX_BACKWARD: top = (1 << LEVEL_W) - 1;
        default:                           top = (1 << BAND_W) - 1;
      endcase
      if (extremes) begin
        value = $urandom_range(1) ? top : 0;
      end else if (top == 1 || $urandom_range(4) == 0) begin
        value = $urandom_range(top);
      end else if (top < 1000) begin
        value = $urandom_range(100, 10);
      end else begin
        value = $urandom_range(1500);
      end
      write_register(idx, value);
    end
  endtask

  // Realistic driving: a pedal (or direction pin and throttle) held for a stretch of ticks
  // at the usual tick period, so the speed really ramps up, brakes and reverses. Some
  // ticks are pure noise and a few carry an emergency stop or a long elapsed time.
  task automatic run_drive_bursts(input int count);
    tick_t t;
    int    sent;
    int    hold;
    int    dir;
    int    pedal;
    int    thr;
    int    k;
    sent = 0;
    while (sent < count) begin
      dir   = $urandom_range(9);
      pedal = ($urandom_range(9) == 0) ? $urandom_range(127, 101) : $urandom_range(100, 1);
      thr   = ($urandom_range(9) == 0) ? $urandom_range(127, 101) : $urandom_range(100, 0);
      hold  = $urandom_range(40, 1);
      for (k = 0; k < hold && sent < count; k++) begin
        if ($urandom_range(99) < 12) begin
          t = tick_t'($urandom);
          t.forward_level  = LEVEL_W'($urandom);
          t.backward_level = LEVEL_W'($urandom);
        end else begin
          // dir 0..3 forward, 4..6 backward, 7 both pressed, 8..9 released
          t.forward_level  = (dir <= 3 || dir == 7) ? LEVEL_W'(pedal) : '0;
          t.backward_level = (dir >= 4 && dir <= 7) ? LEVEL_W'(pedal) : '0;
          t.throttle_level = ($urandom_range(15) == 0) ? '0 : LEVEL_W'(thr);
          t.elapsed_ms     = ($urandom_range(19) == 0) ? MS_W'($urandom)
                                                       : MS_W'($urandom_range(40, 5));
          t.emergency_stop = ($urandom_range(49) == 0);
        end
        send_request(t);
        sent++;
      end
    end
  endtask

  // Hand-picked ticks: every ramp branch, both band snaps, limits above one hundred,
  // elapsed time at both ends, emergency stop, then the pin mode with extreme settings.
  task automatic test_directed_ramp;
    src_idle_pct   = 35;
    sink_stall_pct = 72;
    // Reset defaults: two pedals, limits of fifty percent, bands of ten percent.
    send_tick(100, 0, 0, 20, 0);    // from rest: plain increment
    send_tick(0, 0, 0, 20, 0);      // inside the forward band above target: snap to zero
    send_tick(100, 0, 0, 20, 0);
    send_tick(100, 0, 0, 20, 0);    // inside the forward band below target: jump to its edge
    send_tick(100, 0, 0, 20, 0);
    send_tick(127, 0, 0, 20, 0);    // pedal above one hundred saturates at the limit
    send_tick(100, 100, 0, 20, 0);  // both pedals: target zero, proportional braking
    send_tick(0, 0, 0, 1023, 0);    // longest elapsed time: braking clamped at the target
    send_tick(0, 100, 0, 20, 0);    // from rest backwards: subtract the increment
    send_tick(100, 0, 0, 0, 0);     // inside the backward band below target: snap to zero
    send_tick(0, 100, 0, 20, 0);
    send_tick(0, 100, 0, 20, 0);    // inside the backward band above target: jump to its edge
    send_tick(0, 100, 0, 20, 0);
    send_tick(1, 0, 0, 1023, 0);    // tiny pedal truncates to zero target: brake from reverse
    send_tick(100, 0, 0, 20, 1);    // emergency stop overrides everything
    wait_until_idle();
    // Throttle and pins, forward limit above one hundred, backward limit zero, no forward
    // band, widest backward band, largest increments, drag on.
    write_register(REG_SPEED_DIR_MODE, 1);
    write_register(REG_MAX_FORWARD, 127);
    write_register(REG_MAX_BACKWARD, 0);
    write_register(REG_DRAG_MODE, 1);
    write_register(REG_FWD_SHUTOFF, 0);
    write_register(REG_BWD_SHUTOFF, (1 << BAND_W) - 1);
    write_register(REG_NORMAL_INC, (1 << BAND_W) - 1);
    write_register(REG_DRAG_INC, (1 << BAND_W) - 1);
    send_tick(1, 0, 0, 20, 0);        // pin pressed but throttle closed: no target
    send_tick(1, 0, 127, 20, 0);      // full throttle, drag step clamped at full speed
    send_tick(127, 127, 100, 1023, 0); // both pins: fast braking above half speed
    send_tick(0, 1, 100, 0, 0);       // backward limit zero, no time elapsed: speed kept
    send_tick(0, 1, 100, 1023, 0);    // slow braking down to zero
    send_tick(0, 127, 127, 1023, 0);  // already at target
    wait_until_idle();
  endtask

  // Holds the result channel off for a long stretch while requests keep coming, so the
  // pipeline fills and the block stops taking requests; then lets everything drain
  // before sending more.
  task automatic test_backpressure;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    hold_cycles_req = 80;
    hold_req_seq++;
    run_drive_bursts(30);
    wait_until_idle();
    sink_stall_pct = 40;
    run_drive_bursts(15);
    wait_until_idle();
  endtask

  // Three idling profiles, each with three register settings, one of them at the extremes.
  task automatic test_random_traffic;
    int profile;
    int setting;
    for (profile = 0; profile < 3; profile++) begin
      case (profile)
        0:       begin src_idle_pct = 35; sink_stall_pct = 72; end
        1:       begin src_idle_pct = 72; sink_stall_pct = 35; end
        default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      endcase
      for (setting = 0; setting < 3; setting++) begin
        wait_until_idle();
        apply_random_settings(setting == 1);
        run_drive_bursts(143);
      end
    end
    wait_until_idle();
  endtask

  initial begin
    rst_n                 = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    req_if.valid          = 1'b0;
    req_if.forward_level  = '0;
    req_if.backward_level = '0;
    req_if.throttle_level = '0;
    req_if.elapsed_ms     = '0;
    req_if.emergency_stop = 1'b0;
    res_if.ready          = 1'b0;
    cfg_speed_dir         = 1'b0;
    cfg_max_fwd           = RST_MAX_PERCENT;
    cfg_max_bwd           = RST_MAX_PERCENT;
    cfg_drag              = 1'b0;
    cfg_fwd_shutoff       = RST_SHUTOFF;
    cfg_bwd_shutoff       = RST_SHUTOFF;
    cfg_normal_inc        = RST_NORMAL_INC;
    cfg_drag_inc          = RST_DRAG_INC;
    kept_speed            = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_ramp();
    test_backpressure();
    test_random_traffic();

    // Anything arriving during this settling time has no expectation and is flagged.
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/psrc_pkg.sv
hw/rtl/psrc_chan_if.sv
hw/rtl/pedal_speed_ramp_controller_core.sv
test/tb_top.sv
